// ===== design/slfr_pkg.sv =====
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants for the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

    // Header bytes counted in the length byte: sync 1, sync 2, third, length
    localparam logic [7:0] FRAME_OVERHEAD = 8'd4;

    localparam logic [7:0] TIMEOUT_RELOAD_RST = 8'd10;

    // Input action codes
    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST     = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_RELOAD = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic       store_valid;
        logic [8:0] store_index;
        logic [7:0] store_byte;
        logic       frame_last;
        logic       frame_held;
        logic       hunt_restart;
    } out_t;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] timeout_reload;
    } cfg_t;

endpackage

// ===== design/slfr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// slfr_cfg_regs
// Configuration register file: sync byte values and timeout reload.
// ----------------------------------------------------------------------------
module slfr_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output slfr_pkg::cfg_t      cfg
);
    import slfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_FIRST:     cfg_next.sync_first     = cfg_data;
                REG_SYNC_SECOND:    cfg_next.sync_second    = cfg_data;
                REG_TIMEOUT_RELOAD: cfg_next.timeout_reload = cfg_data;
                default:            cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first     <= 8'd0;
            cfg_reg.sync_second    <= 8'd0;
            cfg_reg.timeout_reload <= TIMEOUT_RELOAD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/slfr_step.sv =====
// ----------------------------------------------------------------------------
// slfr_step
// Receiver state (phase, position, remaining count, timeout) and the
// combinational update that produces one result per accepted transaction.
// ----------------------------------------------------------------------------
module slfr_step (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  slfr_pkg::in_t   in_data,
    input  slfr_pkg::cfg_t  cfg,
    output slfr_pkg::out_t  res
);
    import slfr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_THIRD = 3'd2,
        PH_LEN   = 3'd3,
        PH_BODY  = 3'd4,
        PH_HELD  = 3'd5
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic [8:0] wpos_reg,   wpos_next;
    logic [7:0] remain_reg, remain_next;
    logic [7:0] tmo_reg,    tmo_next;

    logic [8:0] wpos_inc;
    logic [7:0] remain_dec;
    logic [7:0] tmo_dec;

    assign wpos_inc   = wpos_reg + 9'd1;
    assign remain_dec = remain_reg - 8'd1;
    assign tmo_dec    = (tmo_reg != 8'd0) ? (tmo_reg - 8'd1) : 8'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        wpos_next   = wpos_reg;
        remain_next = remain_reg;
        tmo_next    = tmo_reg;
        res         = '0;

        case (in_data.action)
            ACT_BYTE:
            begin
                if (phase_reg != PH_HELD)
                begin
                    tmo_next = cfg.timeout_reload;
                    case (phase_reg)
                        PH_HUNT:
                        begin
                            if (in_data.rx_byte == cfg.sync_first)
                            begin
                                res.store_valid = 1'b1;
                                wpos_next       = 9'd1;
                                phase_next      = PH_SYNC2;
                            end
                        end
                        PH_SYNC2:
                        begin
                            if (in_data.rx_byte == cfg.sync_second)
                            begin
                                res.store_valid = 1'b1;
                                res.store_index = wpos_reg;
                                wpos_next       = wpos_inc;
                                phase_next      = PH_THIRD;
                            end
                            else if (in_data.rx_byte == cfg.sync_first)
                            begin
                                // repeated sync 1 restarts the frame
                                res.store_valid = 1'b1;
                                wpos_next       = 9'd1;
                            end
                            else
                            begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_THIRD, PH_LEN, PH_BODY:
                        begin
                            res.store_valid = 1'b1;
                            res.store_index = wpos_reg;
                            wpos_next       = wpos_inc;
                            if (phase_reg == PH_THIRD)
                            begin
                                phase_next = PH_LEN;
                            end
                            else if (phase_reg == PH_LEN)
                            begin
                                // wraps: a length of 4 gives 256 body bytes
                                remain_next = in_data.rx_byte - FRAME_OVERHEAD;
                                phase_next  = PH_BODY;
                            end
                            else
                            begin
                                remain_next = remain_dec;
                                if (remain_dec == 8'd0)
                                begin
                                    res.frame_last = 1'b1;
                                    phase_next     = PH_HELD;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_HUNT;
                        end
                    endcase
                    res.store_byte = res.store_valid ? in_data.rx_byte : 8'd0;
                end
            end
            ACT_TICK:
            begin
                tmo_next = tmo_dec;
                if ((tmo_dec == 8'd0) && (phase_reg != PH_HELD))
                begin
                    phase_next       = PH_HUNT;
                    remain_next      = 8'd0;
                    res.hunt_restart = 1'b1;
                end
            end
            ACT_RELEASE:
            begin
                if (phase_reg == PH_HELD)
                begin
                    phase_next  = PH_HUNT;
                    remain_next = 8'd0;
                end
            end
            default:
            begin
                phase_next = phase_reg;  // unused action: no effect
            end
        endcase

        res.frame_held = (phase_next == PH_HELD);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            wpos_reg   <= 9'd0;
            remain_reg <= 8'd0;
            tmo_reg    <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            wpos_reg   <= wpos_next;
            remain_reg <= remain_next;
            tmo_reg    <= tmo_next;
        end
    end

    // Assertions
    a_last_enters_held: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.frame_last |=> phase_reg == PH_HELD)
        else $error("frame_last without entering held phase");

    a_restart_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.hunt_restart |-> !res.store_valid && phase_next == PH_HUNT)
        else $error("timeout restart stored a byte or missed hunting");

    a_held_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == PH_HELD |-> !res.store_valid && !res.hunt_restart)
        else $error("activity while frame held");

    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        wpos_reg <= 9'd260)
        else $error("write position beyond frame size");

endmodule

// ===== design/slfr_out_stage.sv =====
// ----------------------------------------------------------------------------
// slfr_out_stage
// Result register with valid/stall; back-pressure to the input side.
// ----------------------------------------------------------------------------
module slfr_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  slfr_pkg::out_t  res,
    output logic            out_valid,
    input  logic            out_stall,
    output slfr_pkg::out_t  out_data,
    output logic            accept
);
    import slfr_pkg::*;

    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;

    // Stall input only while a held result is not being taken
    assign in_stall       = out_valid_reg & out_stall;
    assign accept         = in_valid & ~in_stall;
    assign out_valid_next = accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/sync_length_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_unit
// The result of a transaction is registered and is on out_data the cycle after
//   acceptance. Throughput: 1 transaction per cycle while no waiting result is
//   held by out_stall; the combinational state update feeds the result register.
// Reset: rst_n clears phase, position, counters, result valid and config
//   (timeout reload returns to 10).
// ----------------------------------------------------------------------------
//
// Receives bytes, timer ticks and release commands. Hunts for sync 1 then
// sync 2, takes a third byte and a length byte, then stores length - 4 body
// bytes (8-bit wrap) and holds the frame until released. Each received byte
// reloads the timeout; a tick that reaches zero forces a return to hunting
// unless a frame is held.
//
module sync_length_frame_receiver_unit (
    input  logic            clk,
    input  logic            rst_n,
    // input channel
    input  logic            in_valid,
    output logic            in_stall,
    input  slfr_pkg::in_t   in_data,
    // result channel
    output logic            out_valid,
    input  logic            out_stall,
    output slfr_pkg::out_t  out_data,
    // configuration write port
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);
    import slfr_pkg::*;

    cfg_t cfg;      // live register values
    out_t res;      // combinational result of the current transaction
    logic accept;   // input transaction taken this cycle

    slfr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Frame state machine; updates only on an accepted transaction
    slfr_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .cfg     (cfg),
        .res     (res)
    );

    // Result register; a waiting result stalls input only while out_stall
    slfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res       (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .accept    (accept)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sync/length frame receiver: directed header,
// length-wrap, hold, release and timeout sequences, then randomized frames,
// broken headers and noise under several register settings, with every
// result checked field by field against a cycle-free behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
    import slfr_pkg::*;

    typedef enum logic [2:0] {
        HUNT_SYNC1,
        EXPECT_SYNC2,
        TAKE_THIRD,
        TAKE_LENGTH,
        TAKE_BODY,
        FRAME_HOLD
    } rx_phase_t;

    // Tracks receiver state, predicts one result per input transaction and
    // checks the results in order.
    class frame_scoreboard;
        cfg_t       settings;
        rx_phase_t  rx_phase;
        logic [8:0] position;
        logic [7:0] remaining;
        logic [7:0] countdown;
        out_t       pending_frame_results[$];
        int         error_count;
        int         results_seen;

        function new();
            settings.sync_first     = 8'd0;
            settings.sync_second    = 8'd0;
            settings.timeout_reload = TIMEOUT_RELOAD_RST;
            rx_phase     = HUNT_SYNC1;
            position     = '0;
            remaining    = '0;
            countdown    = '0;
            error_count  = 0;
            results_seen = 0;
        endfunction

        function void write_setting(logic [1:0] index, logic [7:0] value);
            case (index)
                REG_SYNC_FIRST:     settings.sync_first     = value;
                REG_SYNC_SECOND:    settings.sync_second    = value;
                REG_TIMEOUT_RELOAD: settings.timeout_reload = value;
                default: ;
            endcase
        endfunction

        function out_t predict_receiver_step(in_t item);
            out_t r;
            r = '0;
            case (item.action)
                ACT_BYTE:
                    if (rx_phase != FRAME_HOLD) begin
                        countdown = settings.timeout_reload;
                        case (rx_phase)
                            HUNT_SYNC1:
                                if (item.rx_byte == settings.sync_first) begin
                                    r.store_valid = 1'b1;
                                    r.store_index = 9'd0;
                                    position      = 9'd1;
                                    rx_phase      = EXPECT_SYNC2;
                                end
                            EXPECT_SYNC2:
                                if (item.rx_byte == settings.sync_second) begin
                                    r.store_valid = 1'b1;
                                    r.store_index = position;
                                    position      = position + 9'd1;
                                    rx_phase      = TAKE_THIRD;
                                end else if (item.rx_byte == settings.sync_first) begin
                                    // a repeated sync 1 restarts the frame
                                    r.store_valid = 1'b1;
                                    r.store_index = 9'd0;
                                    position      = 9'd1;
                                end else begin
                                    rx_phase = HUNT_SYNC1;
                                end
                            default:
                            begin
                                r.store_valid = 1'b1;
                                r.store_index = position;
                                position      = position + 9'd1;
                                if (rx_phase == TAKE_THIRD) begin
                                    rx_phase = TAKE_LENGTH;
                                end else if (rx_phase == TAKE_LENGTH) begin
                                    // 8-bit wrap: a length of 4 gives 256 body bytes
                                    remaining = item.rx_byte - FRAME_OVERHEAD;
                                    rx_phase  = TAKE_BODY;
                                end else begin
                                    remaining = remaining - 8'd1;
                                    if (remaining == 8'd0) begin
                                        r.frame_last = 1'b1;
                                        rx_phase     = FRAME_HOLD;
                                    end
                                end
                            end
                        endcase
                    end
                ACT_TICK:
                begin
                    if (countdown != 8'd0)
                        countdown = countdown - 8'd1;
                    if (countdown == 8'd0 && rx_phase != FRAME_HOLD) begin
                        rx_phase       = HUNT_SYNC1;
                        remaining      = 8'd0;
                        r.hunt_restart = 1'b1;
                    end
                end
                ACT_RELEASE:
                    if (rx_phase == FRAME_HOLD) begin
                        rx_phase  = HUNT_SYNC1;
                        remaining = 8'd0;
                    end
                default: ;
            endcase
            if (r.store_valid)
                r.store_byte = item.rx_byte;
            r.frame_held = (rx_phase == FRAME_HOLD);
            return r;
        endfunction

        function void note_input(in_t item);
            pending_frame_results.push_back(predict_receiver_step(item));
        endfunction

        function int pending_count();
            return pending_frame_results.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            error_count++;
        endtask

        task check_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                          results_seen, name, got, want));
        endtask

        task check_result(out_t got);
            out_t want;
            if (pending_frame_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing pending",
                                          results_seen));
            end else begin
                want = pending_frame_results.pop_front();
                check_field("store_valid",  32'(got.store_valid),  32'(want.store_valid));
                check_field("store_index",  32'(got.store_index),  32'(want.store_index));
                check_field("store_byte",   32'(got.store_byte),   32'(want.store_byte));
                check_field("frame_last",   32'(got.frame_last),   32'(want.frame_last));
                check_field("frame_held",   32'(got.frame_held),   32'(want.frame_held));
                check_field("hunt_restart", 32'(got.hunt_restart), 32'(want.hunt_restart));
            end
            results_seen++;
        endtask
    endclass

    // Action code 3 has no function; the block must ignore it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int DIRECTED_ITEMS = 28;
    localparam int RANDOM_ITEMS   = 1325;
    // Slowest run is roughly 1700 transactions with heavy idling on both sides;
    // the limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT    = 300000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    logic       cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    frame_scoreboard sb;

    int unsigned send_gap_pct = 24;  // chance the sender idles a cycle
    int unsigned stall_pct    = 85;  // chance the receiver stalls a cycle
    int          inputs_accepted = 0;
    int          items_sent = 0;
    int          cycle_count = 0;

    sync_length_frame_receiver_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Result-side backpressure, redrawn every cycle from the current rate.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Monitor: both channels are sampled at the rising edge, before the block
    // updates. The result check runs first, so a transaction's expectation is
    // only ever matched against results from later edges.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            if (in_valid && !in_stall) begin
                sb.note_input(in_data);
                inputs_accepted++;
            end
        end
    end

    // Watchdog: a run that has not finished by the limit counts as failed.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Drive one input transaction. Called at a falling edge and returns at the
    // falling edge after the transaction was accepted. Valid stays high from
    // one transaction into the next unless a gap is drawn.
    task automatic send_item(input logic [1:0] action, input logic [7:0] value);
        in_t item;
        int  seen;
        item.action  = action;
        item.rx_byte = value;
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        seen = inputs_accepted;
        do
            @(negedge clk);
        while (inputs_accepted == seen);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result has been checked.
    // Each transaction yields exactly one result, so the block is then idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        sb.write_setting(index, value);
        @(negedge clk);
    endtask

    task automatic load_settings(input logic [7:0] first, input logic [7:0] second,
                                 input logic [7:0] reload);
        write_register(REG_SYNC_FIRST, first);
        write_register(REG_SYNC_SECOND, second);
        write_register(REG_TIMEOUT_RELOAD, reload);
        cfg_we <= 1'b0;
    endtask

    // Well-formed frame with random content: optional leading noise, sync
    // bytes (sometimes a repeated sync 1), third byte, length, body with the
    // odd tick mixed in, then bytes/ticks while held and usually a release.
    task automatic send_random_frame(input logic [7:0] length_byte);
        logic [7:0]  body_left;
        int unsigned body_count;
        body_left  = length_byte - FRAME_OVERHEAD;
        body_count = (body_left == 8'd0) ? 256 : 32'(body_left);
        if ($urandom_range(99) < 20)
            send_item(ACT_BYTE, 8'($urandom_range(255)));
        send_item(ACT_BYTE, sb.settings.sync_first);
        if ($urandom_range(99) < 10 && sb.settings.sync_first != sb.settings.sync_second)
            send_item(ACT_BYTE, sb.settings.sync_first);
        send_item(ACT_BYTE, sb.settings.sync_second);
        send_item(ACT_BYTE, 8'($urandom_range(255)));
        send_item(ACT_BYTE, length_byte);
        repeat (body_count) begin
            if ($urandom_range(99) < 6)
                send_item(ACT_TICK, 8'($urandom_range(255)));
            send_item(ACT_BYTE, 8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 30)
            send_item(ACT_BYTE, 8'($urandom_range(255)));
        if ($urandom_range(99) < 30)
            send_item(ACT_TICK, 8'($urandom_range(255)));
        if ($urandom_range(99) < 85)
            send_item(ACT_RELEASE, 8'($urandom_range(255)));
    endtask

    initial begin
        int          k;
        int unsigned pick;
        int unsigned progress;
        int unsigned tick_count;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [7:0]  reload;

        sb = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed part, reset settings ----------------
        // sync 1 = sync 2 = 0, timeout reload 10
        send_item(ACT_UNUSED, 8'hFF);   // unused action: ignored
        send_item(ACT_RELEASE, 8'hFF);  // release with nothing held
        send_item(ACT_TICK, 8'h00);     // timer already zero while hunting
        send_item(ACT_TICK, 8'hAA);     // ... and again
        send_item(ACT_BYTE, 8'h00);     // sync 1
        send_item(ACT_BYTE, 8'h00);     // sync 2
        send_item(ACT_BYTE, 8'hFF);     // third byte
        send_item(ACT_BYTE, 8'h05);     // length 5: one body byte
        send_item(ACT_BYTE, 8'hAA);     // last byte, frame now held
        send_item(ACT_BYTE, 8'h00);     // byte while held: ignored
        send_item(ACT_TICK, 8'h00);     // tick while held: no restart
        send_item(ACT_RELEASE, 8'h00);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'h00);
        send_item(ACT_BYTE, 8'h80);
        send_item(ACT_BYTE, 8'h04);     // length 4: remaining count wraps
        send_item(ACT_BYTE, 8'h01);
        send_item(ACT_BYTE, 8'hFE);
        // run the timer out mid-frame; the tenth tick forces hunting
        repeat (10) send_item(ACT_TICK, 8'h55);

        // ---------------- random part ----------------
        for (k = 0; k < 5; k++) begin
            case (k)
                0: begin first = 8'hFF; second = 8'h00; reload = 8'd255; end
                1: begin first = 8'hA5; second = 8'h5A; reload = 8'd3;   end
                2: begin first = 8'h7E; second = 8'h7E; reload = 8'd0;   end
                3: begin first = 8'h00; second = 8'hFF; reload = 8'd1;   end
                default: begin first = 8'h3C; second = 8'hC3; reload = 8'd20; end
            endcase
            // Registers change only with the block idle; this also gives the
            // sender a full pause until every result has come back.
            wait_idle();
            load_settings(first, second, reload);

            // One full 256-byte body (length byte 4) under the longest timeout.
            if (k == 0)
                send_random_frame(FRAME_OVERHEAD);

            while (items_sent < DIRECTED_ITEMS + (k + 1) * RANDOM_ITEMS / 5) begin
                progress = items_sent - DIRECTED_ITEMS;
                if (progress < RANDOM_ITEMS / 3) begin
                    send_gap_pct = 24;
                    stall_pct    = 85;
                end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                    send_gap_pct = 85;
                    stall_pct    = 24;
                end else begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end

                pick = $urandom_range(99);
                if (pick < 70) begin
                    // mostly short frames, now and then a near-256-byte one
                    if ($urandom_range(99) == 0)
                        send_random_frame(8'($urandom_range(4)));
                    else
                        send_random_frame(8'($urandom_range(14, 5)));
                end else if (pick < 85) begin
                    // broken header: random second byte, or ticks in the header
                    // that run the timer out when the reload is at most 12
                    send_item(ACT_BYTE, sb.settings.sync_first);
                    if ($urandom_range(1)) begin
                        send_item(ACT_BYTE, 8'($urandom_range(255)));
                    end else begin
                        send_item(ACT_BYTE, sb.settings.sync_second);
                        tick_count = (sb.settings.timeout_reload <= 8'd12) ?
                                     sb.settings.timeout_reload + 1 : $urandom_range(4, 1);
                        repeat (tick_count) send_item(ACT_TICK, 8'($urandom_range(255)));
                    end
                end else begin
                    // noise: any action, any byte
                    repeat ($urandom_range(6, 1))
                        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
                end
            end
        end

        wait_idle();
        repeat (4) @(negedge clk);
        if (sb.error_count == 0 && sb.pending_count() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/slfr_pkg.sv
design/slfr_cfg_regs.sv
design/slfr_step.sv
design/slfr_out_stage.sv
design/sync_length_frame_receiver_unit.sv
tb/testbench.sv
